FILE: hdl/packed_2bpp_display_adapter_assert.svh
// Assertion macros shared by the display adapter checkers.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef PACKED_2BPP_DISPLAY_ADAPTER_ASSERT_SVH
`define PACKED_2BPP_DISPLAY_ADAPTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define P2BDA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define P2BDA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/p2bda_pkg.sv
// Shared constants and codes for the packed 2bpp display adapter.
// No dependencies.
package p2bda_pkg;

    localparam int VRAM_BYTES_DEF    = 32768;
    localparam int SCREEN_WIDTH_DEF  = 400;
    localparam int SCREEN_HEIGHT_DEF = 300;

    localparam int ADDR_W = 18;
    localparam int DATA_W = 16;
    localparam int OP_W   = 3;
    localparam int PIX_W  = 9;
    localparam int RGB_W  = 24;
    localparam int ST_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_RD_WORD = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_WORD = 3'd1;
    localparam logic [OP_W-1:0] OP_RD_BYTE = 3'd2;
    localparam logic [OP_W-1:0] OP_WR_BYTE = 3'd3;
    localparam logic [OP_W-1:0] OP_SCAN    = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_BADADDR   = 3'd1;
    localparam logic [ST_W-1:0] ST_FUNCREAD  = 3'd2;
    localparam logic [ST_W-1:0] ST_BYTEREG   = 3'd3;
    localparam logic [ST_W-1:0] ST_OFFSCREEN = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_VRAM_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_ADDR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARG0_ADDR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARG1_ADDR = 2'd3;

    localparam logic [ADDR_W-1:0] VRAM_BASE_RST = 18'o0200000;
    localparam logic [ADDR_W-1:0] FUNC_ADDR_RST = 18'o0300000;
    localparam logic [ADDR_W-1:0] ARG0_ADDR_RST = 18'o0300002;
    localparam logic [ADDR_W-1:0] ARG1_ADDR_RST = 18'o0300004;

    localparam logic [3:0] FN_CLEAR = 4'b1001;
    localparam logic [3:0] FN_PLOT  = 4'b0001;

    localparam logic [7:0] PIX_MASK = 8'h03;

endpackage

FILE: hdl/packed_2bpp_display_adapter.sv
// Packed 2bpp display adapter: bus decode, VRAM, argument registers, scan-out.
// Depends on p2bda_pkg.
//
// The VRAM is one single-port byte memory with a registered read, so every
// item runs one at a time through a small sequencer: a word access touches
// two bytes, a scan-out read reads one byte and a pixel plot reads and then
// rewrites its byte, and CLEAR writes every byte. After reset a clearing
// pass zeroes the VRAM with in_ready low; configuration writes are taken
// throughout.
// Results sit in an output register, so the next item is taken while the
// previous result waits for out_ready.
module packed_2bpp_display_adapter #(
    parameter int VRAM_BYTES    = p2bda_pkg::VRAM_BYTES_DEF,
    parameter int SCREEN_WIDTH  = p2bda_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = p2bda_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [p2bda_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [p2bda_pkg::ADDR_W-1:0]        cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [p2bda_pkg::OP_W-1:0]          opcode,
    input  logic [p2bda_pkg::ADDR_W-1:0]        address,
    input  logic [p2bda_pkg::DATA_W-1:0]        write_data,
    input  logic [p2bda_pkg::PIX_W-1:0]         pixel_x,
    input  logic [p2bda_pkg::PIX_W-1:0]         pixel_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [p2bda_pkg::DATA_W-1:0]        read_data,
    output logic [p2bda_pkg::RGB_W-1:0]         pixel_rgb,
    output logic [p2bda_pkg::ST_W-1:0]          status
);
    import p2bda_pkg::*;

    localparam int AW    = $clog2(VRAM_BYTES);
    localparam int SW_W  = $clog2(SCREEN_WIDTH + 1);
    localparam int IDX_W = DATA_W + SW_W + 1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RW1  = 9'b000000010,
        S_RW2  = 9'b000000100,
        S_RB   = 9'b000001000,
        S_WW   = 9'b000010000,
        S_PIX  = 9'b000100000,
        S_PIXR = 9'b001000000,
        S_CLR  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] vram_base_reg, func_addr_reg, arg0_addr_reg, arg1_addr_reg;
    logic [DATA_W-1:0] arg_x_reg, arg_x_next, arg_y_reg, arg_y_next;

    logic [AW-1:0]     off_reg, off_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              pix_set_reg, pix_set_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [7:0]        clr_fill_reg, clr_fill_next;
    logic              clr_resp_reg, clr_resp_next;

    logic [DATA_W-1:0] res_rd_reg, res_rd_next;
    logic [RGB_W-1:0]  res_rgb_reg, res_rgb_next;
    logic [ST_W-1:0]   res_st_reg, res_st_next;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_rd_reg, out_rd_next;
    logic [RGB_W-1:0]  out_rgb_reg, out_rgb_next;
    logic [ST_W-1:0]   out_st_reg, out_st_next;

    logic [7:0]        vram [VRAM_BYTES];
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata_reg;

    logic [ADDR_W-1:0] vram_diff;
    logic              in_vram, last_byte;
    logic [AW-1:0]     vram_off;
    logic              hit_fn, hit_a0, hit_a1, off_screen;
    logic [DATA_W-1:0] mul_x, mul_y;
    logic [IDX_W-1:0]  idx_calc;
    logic [2:0]        pix_sh;
    logic [7:0]        pix_bmask;
    logic [1:0]        pix_val;
    logic              out_free;

    assign vram_diff = address - vram_base_reg;
    assign in_vram   = (address >= vram_base_reg) && (vram_diff < ADDR_W'(VRAM_BYTES));
    assign vram_off  = vram_diff[AW-1:0];
    assign last_byte = (vram_off == AW'(VRAM_BYTES - 1));
    assign hit_fn    = (address == func_addr_reg);
    assign hit_a0    = (address == arg0_addr_reg);
    assign hit_a1    = (address == arg1_addr_reg);
    assign off_screen = ({1'b0, pixel_x} >= (PIX_W + 1)'(SCREEN_WIDTH))
                     || ({1'b0, pixel_y} >= (PIX_W + 1)'(SCREEN_HEIGHT));

    assign mul_x    = (opcode == OP_SCAN) ? {{(DATA_W - PIX_W){1'b0}}, pixel_x} : arg_x_reg;
    assign mul_y    = (opcode == OP_SCAN) ? {{(DATA_W - PIX_W){1'b0}}, pixel_y} : arg_y_reg;
    assign idx_calc = IDX_W'(mul_x) + IDX_W'(mul_y) * IDX_W'(SCREEN_WIDTH);

    assign pix_sh    = {idx_reg[1:0], 1'b0};
    assign pix_bmask = PIX_MASK << pix_sh;
    assign pix_val   = 2'(mem_rdata_reg >> pix_sh);

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign read_data = out_rd_reg;
    assign pixel_rgb = out_rgb_reg;
    assign status    = out_st_reg;

    always_comb
    begin
        state_next     = state_reg;
        arg_x_next     = arg_x_reg;
        arg_y_next     = arg_y_reg;
        off_next       = off_reg;
        idx_next       = idx_reg;
        data_next      = data_reg;
        pix_set_next   = pix_set_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_fill_next  = clr_fill_reg;
        clr_resp_next  = clr_resp_reg;
        res_rd_next    = res_rd_reg;
        res_rgb_next   = res_rgb_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_rd_next    = out_rd_reg;
        out_rgb_next   = out_rgb_reg;
        out_st_next    = out_st_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = off_reg;
        mem_wdata      = data_reg[7:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    data_next    = write_data;
                    off_next     = vram_off;
                    res_rd_next  = '0;
                    res_rgb_next = '0;
                    res_st_next  = ST_OK;
                    state_next   = S_DONE;
                    if (opcode == OP_SCAN)
                    begin
                        if (off_screen)
                        begin
                            res_st_next = ST_OFFSCREEN;
                        end
                        else
                        begin
                            idx_next     = idx_calc;
                            pix_set_next = 1'b0;
                            state_next   = S_PIX;
                        end
                    end
                    else if (opcode > OP_SCAN)
                    begin
                        res_st_next = ST_BADADDR;
                    end
                    else if (in_vram)
                    begin
                        case (opcode)
                            OP_RD_WORD:
                            begin
                                if (last_byte)
                                begin
                                    res_st_next = ST_BADADDR;
                                end
                                else
                                begin
                                    mem_re     = 1'b1;
                                    mem_addr   = vram_off;
                                    state_next = S_RW1;
                                end
                            end
                            OP_WR_WORD:
                            begin
                                if (last_byte)
                                begin
                                    res_st_next = ST_BADADDR;
                                end
                                else
                                begin
                                    mem_we     = 1'b1;
                                    mem_addr   = vram_off;
                                    mem_wdata  = write_data[7:0];
                                    state_next = S_WW;
                                end
                            end
                            OP_RD_BYTE:
                            begin
                                mem_re     = 1'b1;
                                mem_addr   = vram_off;
                                state_next = S_RB;
                            end
                            OP_WR_BYTE:
                            begin
                                mem_we    = 1'b1;
                                mem_addr  = vram_off;
                                mem_wdata = write_data[7:0];
                            end
                            default:
                            begin
                                res_st_next = ST_BADADDR;
                            end
                        endcase
                    end
                    else if (hit_fn || hit_a0 || hit_a1)
                    begin
                        if (opcode inside {OP_RD_BYTE, OP_WR_BYTE})
                        begin
                            res_st_next = ST_BYTEREG;
                        end
                        else if (hit_fn)
                        begin
                            if (opcode == OP_RD_WORD)
                            begin
                                res_st_next = ST_FUNCREAD;
                            end
                            else
                            begin
                                case (write_data[15:12])
                                    FN_CLEAR:
                                    begin
                                        clr_cnt_next  = '0;
                                        clr_fill_next = write_data[7:0];
                                        clr_resp_next = 1'b1;
                                        state_next    = S_CLR;
                                    end
                                    FN_PLOT:
                                    begin
                                        idx_next     = idx_calc;
                                        pix_set_next = 1'b1;
                                        state_next   = S_PIX;
                                    end
                                    default:
                                    begin
                                        res_st_next = ST_OK;
                                    end
                                endcase
                            end
                        end
                        else if (hit_a0)
                        begin
                            if (opcode == OP_RD_WORD)
                                res_rd_next = arg_x_reg;
                            else
                                arg_x_next = write_data;
                        end
                        else
                        begin
                            if (opcode == OP_RD_WORD)
                                res_rd_next = arg_y_reg;
                            else
                                arg_y_next = write_data;
                        end
                    end
                    else
                    begin
                        res_st_next = ST_BADADDR;
                    end
                end
            end
            S_RW1:
            begin
                res_rd_next[7:0] = mem_rdata_reg;
                mem_re           = 1'b1;
                mem_addr         = off_reg + AW'(1);
                state_next       = S_RW2;
            end
            S_RW2:
            begin
                res_rd_next[15:8] = mem_rdata_reg;
                state_next        = S_DONE;
            end
            S_RB:
            begin
                res_rd_next = {8'h00, mem_rdata_reg};
                state_next  = S_DONE;
            end
            S_WW:
            begin
                mem_we     = 1'b1;
                mem_addr   = off_reg + AW'(1);
                mem_wdata  = data_reg[15:8];
                state_next = S_DONE;
            end
            S_PIX:
            begin
                if ({2'b00, idx_reg[IDX_W-1:2]} >= IDX_W'(VRAM_BYTES))
                begin
                    res_st_next = ST_BADADDR;
                    state_next  = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_addr   = idx_reg[AW+1:2];
                    state_next = S_PIXR;
                end
            end
            S_PIXR:
            begin
                if (pix_set_reg)
                begin
                    mem_we    = 1'b1;
                    mem_addr  = idx_reg[AW+1:2];
                    mem_wdata = (mem_rdata_reg & ~pix_bmask)
                              | (({6'b0, data_reg[1:0]} << pix_sh) & pix_bmask);
                end
                else
                begin
                    res_rgb_next = {12{pix_val}};
                end
                state_next = S_DONE;
            end
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = clr_fill_reg;
                if (clr_cnt_reg == AW'(VRAM_BYTES - 1))
                    state_next = clr_resp_reg ? S_DONE : S_IDLE;
                else
                    clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rd_next    = res_rd_reg;
                    out_rgb_next   = res_rgb_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            vram[mem_addr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= vram[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            clr_fill_reg  <= '0;
            clr_resp_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            arg_x_reg     <= '0;
            arg_y_reg     <= '0;
            vram_base_reg <= VRAM_BASE_RST;
            func_addr_reg <= FUNC_ADDR_RST;
            arg0_addr_reg <= ARG0_ADDR_RST;
            arg1_addr_reg <= ARG1_ADDR_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_fill_reg  <= clr_fill_next;
            clr_resp_reg  <= clr_resp_next;
            out_valid_reg <= out_valid_next;
            arg_x_reg     <= arg_x_next;
            arg_y_reg     <= arg_y_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_VRAM_BASE: vram_base_reg <= cfg_wdata;
                    CFG_FUNC_ADDR: func_addr_reg <= cfg_wdata;
                    CFG_ARG0_ADDR: arg0_addr_reg <= cfg_wdata;
                    CFG_ARG1_ADDR: arg1_addr_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg     <= off_next;
        idx_reg     <= idx_next;
        data_reg    <= data_next;
        pix_set_reg <= pix_set_next;
        res_rd_reg  <= res_rd_next;
        res_rgb_reg <= res_rgb_next;
        res_st_reg  <= res_st_next;
        out_rd_reg  <= out_rd_next;
        out_rgb_reg <= out_rgb_next;
        out_st_reg  <= out_st_next;
    end

endmodule

FILE: hdl/p2bda_checker.sv
// Port-level checker for the display adapter, bound to the top level.
// Depends on p2bda_pkg and packed_2bpp_display_adapter_assert.svh.
`include "packed_2bpp_display_adapter_assert.svh"

module p2bda_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [p2bda_pkg::DATA_W-1:0]   read_data,
    input logic [p2bda_pkg::RGB_W-1:0]    pixel_rgb,
    input logic [p2bda_pkg::ST_W-1:0]     status
);
    import p2bda_pkg::*;

    // one item in flight: a transfer in closes the input side next cycle
    `P2BDA_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input taken while busy")

    `P2BDA_ASSERT_IMP(a_err_zero, out_valid && status != ST_OK,
        read_data == '0 && pixel_rgb == '0, "error result carries data")

    `P2BDA_ASSERT_IMP(a_grey, out_valid && pixel_rgb != '0,
        pixel_rgb[23:16] == pixel_rgb[15:8] && pixel_rgb[15:8] == pixel_rgb[7:0]
        && read_data == '0, "scan-out pixel not grey")

    `P2BDA_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(read_data) && $stable(pixel_rgb) && $stable(status),
        "stalled result changed")

endmodule

bind packed_2bpp_display_adapter p2bda_checker u_p2bda_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 1ps
// Testbench for packed_2bpp_display_adapter: directed and random bus, register,
// pixel plot, clear and scan-out traffic checked against a behavioral model.
// Depends on p2bda_pkg and the adapter RTL.
module tb;
    import p2bda_pkg::*;

    localparam int VRAM_BYTES = VRAM_BYTES_DEF;
    localparam int SCR_W      = SCREEN_WIDTH_DEF;
    localparam int SCR_H      = SCREEN_HEIGHT_DEF;
    localparam int ADDR_MAX   = (1 << ADDR_W) - 1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
        logic [PIX_W-1:0]  px;
        logic [PIX_W-1:0]  py;
    } bus_access_t;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic [RGB_W-1:0]  rgb;
        logic [ST_W-1:0]   st;
    } bus_response_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [OP_W-1:0]      opcode = '0;
    logic [ADDR_W-1:0]    address = '0;
    logic [DATA_W-1:0]    write_data = '0;
    logic [PIX_W-1:0]     pixel_x = '0;
    logic [PIX_W-1:0]     pixel_y = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [DATA_W-1:0]    read_data;
    logic [RGB_W-1:0]     pixel_rgb;
    logic [ST_W-1:0]      status;

    // shadow of the adapter state
    logic [7:0]        vram_image [VRAM_BYTES];
    logic [15:0]       pen_x;
    logic [15:0]       pen_y;
    logic [ADDR_W-1:0] win_base;
    logic [ADDR_W-1:0] func_addr;
    logic [ADDR_W-1:0] x_addr;
    logic [ADDR_W-1:0] y_addr;

    bus_response_t awaited_responses [$];
    bus_response_t want;
    int            mismatches = 0;
    int            accesses_sent = 0;
    int            clears_left = 5;
    int            send_idle_pct = 37;
    int            recv_stall_pct = 37;

    packed_2bpp_display_adapter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .address    (address),
        .write_data (write_data),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .pixel_rgb  (pixel_rgb),
        .status     (status)
    );

    always #1 clk = ~clk;

    initial
    begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bus_response_t emulate_access(input bus_access_t a);
        bus_response_t r;
        int unsigned   off;
        int unsigned   pix;
        int unsigned   sh;
        logic          in_win;
        logic [1:0]    g;
        logic [7:0]    grey;
        r = '0;
        r.st = ST_OK;
        in_win = (a.addr >= win_base) && (a.addr < win_base + VRAM_BYTES);
        off = 32'(a.addr - win_base);
        if (a.op == OP_SCAN)
        begin
            if (a.px >= SCR_W || a.py >= SCR_H)
                r.st = ST_OFFSCREEN;
            else
            begin
                pix = a.px + a.py * SCR_W;
                if ((pix >> 2) >= VRAM_BYTES)
                    r.st = ST_BADADDR;
                else
                begin
                    g = 2'(vram_image[pix >> 2] >> (2 * (pix % 4)));
                    grey = g * 8'd85;
                    r.rgb = {grey, grey, grey};
                end
            end
        end
        else if (a.op > OP_SCAN)
            r.st = ST_BADADDR;
        else if (in_win)
        begin
            case (a.op)
                OP_RD_WORD, OP_WR_WORD:
                    if (off + 1 >= VRAM_BYTES)
                        r.st = ST_BADADDR;
                    else if (a.op == OP_RD_WORD)
                        r.rdata = {vram_image[off + 1], vram_image[off]};
                    else
                    begin
                        vram_image[off] = a.wdata[7:0];
                        vram_image[off + 1] = a.wdata[15:8];
                    end
                OP_RD_BYTE:
                    r.rdata = {8'h00, vram_image[off]};
                default:
                    vram_image[off] = a.wdata[7:0];
            endcase
        end
        else if (a.addr == func_addr || a.addr == x_addr || a.addr == y_addr)
        begin
            if (a.op == OP_RD_BYTE || a.op == OP_WR_BYTE)
                r.st = ST_BYTEREG;
            else if (a.addr == func_addr)
            begin
                if (a.op == OP_RD_WORD)
                    r.st = ST_FUNCREAD;
                else if (a.wdata[15:12] == FN_CLEAR)
                begin
                    foreach (vram_image[i])
                        vram_image[i] = a.wdata[7:0];
                end
                else if (a.wdata[15:12] == FN_PLOT)
                begin
                    pix = pen_x + pen_y * SCR_W;
                    if ((pix >> 2) >= VRAM_BYTES)
                        r.st = ST_BADADDR;
                    else
                    begin
                        sh = 2 * (pix % 4);
                        vram_image[pix >> 2] = (vram_image[pix >> 2] & ~(PIX_MASK << sh))
                                             | (8'(a.wdata[1:0]) << sh);
                    end
                end
            end
            else if (a.addr == x_addr)
            begin
                if (a.op == OP_RD_WORD)
                    r.rdata = pen_x;
                else
                    pen_x = a.wdata;
            end
            else
            begin
                if (a.op == OP_RD_WORD)
                    r.rdata = pen_y;
                else
                    pen_y = a.wdata;
            end
        end
        else
            r.st = ST_BADADDR;
        return r;
    endfunction

    // result side: check each transfer, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_responses.size() == 0)
                begin
                    $error("result transfer with nothing awaited");
                    mismatches++;
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    if (read_data !== want.rdata)
                    begin
                        $error("read_data expected %h actual %h", want.rdata, read_data);
                        mismatches++;
                    end
                    if (pixel_rgb !== want.rgb)
                    begin
                        $error("pixel_rgb expected %h actual %h", want.rgb, pixel_rgb);
                        mismatches++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status expected %0d actual %0d", want.st, status);
                        mismatches++;
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_access(input bus_access_t a);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= a.op;
        address    <= a.addr;
        write_data <= a.wdata;
        pixel_x    <= a.px;
        pixel_y    <= a.py;
        do
            @(posedge clk);
        while (!in_ready);
        awaited_responses.push_back(emulate_access(a));
        accesses_sent++;
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                         input logic [DATA_W-1:0] data = '0,
                         input int unsigned px = 0, input int unsigned py = 0);
        bus_access_t a;
        a.op    = op;
        a.addr  = addr;
        a.wdata = data;
        a.px    = PIX_W'(px);
        a.py    = PIX_W'(py);
        send_access(a);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic program_map(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] fn,
                               input logic [ADDR_W-1:0] ax, input logic [ADDR_W-1:0] ay);
        logic [ADDR_W-1:0]    vals [4];
        logic [CFG_IDX_W-1:0] idx [4];
        drain();
        vals = '{base, fn, ax, ay};
        idx  = '{CFG_VRAM_BASE, CFG_FUNC_ADDR, CFG_ARG0_ADDR, CFG_ARG1_ADDR};
        for (int i = 0; i < 4; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        win_base  = base;
        func_addr = fn;
        x_addr    = ax;
        y_addr    = ay;
    endtask

    function automatic bus_access_t scatter();
        bus_access_t a;
        a.op    = OP_W'($urandom_range(0, 7));
        a.addr  = ADDR_W'($urandom);
        a.wdata = DATA_W'($urandom);
        a.px    = PIX_W'($urandom);
        a.py    = PIX_W'($urandom);
        return a;
    endfunction

    function automatic bus_access_t random_access();
        bus_access_t a;
        int unsigned pick;
        int unsigned off;
        a = scatter();
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            a.op = OP_W'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: off = VRAM_BYTES - 1;
                1: off = VRAM_BYTES - 2;
                2: off = 0;
                3, 4, 5, 6: off = $urandom_range(0, 255);
                default: off = $urandom_range(0, VRAM_BYTES - 1);
            endcase
            a.addr = ADDR_W'(win_base + off);
        end
        else if (pick < 65)
        begin
            a.op = OP_SCAN;
            if ($urandom_range(0, 99) < 85)
            begin
                a.px = PIX_W'($urandom_range(0, SCR_W - 1));
                a.py = PIX_W'($urandom_range(0, SCR_H - 1));
            end
        end
        else if (pick < 85)
        begin
            a.op = OP_W'($urandom_range(0, 3));
            case ($urandom_range(0, 2))
                0: a.addr = x_addr;
                1: a.addr = y_addr;
                default:
                begin
                    a.addr = func_addr;
                    if ($urandom_range(0, 9) < 7)
                        a.op = OP_WR_WORD;
                    case ($urandom_range(0, 24))
                        0, 1, 2: a.wdata[15:12] = FN_CLEAR;
                        3, 4, 5, 6, 7, 8, 9, 10, 11, 12: a.wdata[15:12] = FN_PLOT;
                        default: ;
                    endcase
                end
            endcase
        end
        // a clear costs a full VRAM pass, so keep them few
        if (a.op == OP_WR_WORD && a.addr == func_addr && a.wdata[15:12] == FN_CLEAR)
        begin
            if (clears_left == 0)
                a.wdata[15] = 1'b0;
            else
                clears_left--;
        end
        return a;
    endfunction

    task automatic pixel_sequence();
        bus_access_t a;
        logic [15:0] x;
        logic [15:0] y;
        int unsigned pix;
        case ($urandom_range(0, 9))
            0:
            begin
                x = 16'($urandom_range(SCR_W, 1023));
                y = 16'($urandom_range(0, SCR_H - 1));
            end
            1:
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            default:
            begin
                x = 16'($urandom_range(0, SCR_W - 1));
                y = 16'($urandom_range(0, SCR_H - 1));
            end
        endcase
        a = scatter();
        a.op    = OP_WR_WORD;
        a.addr  = x_addr;
        a.wdata = x;
        send_access(a);
        a.addr  = y_addr;
        a.wdata = y;
        send_access(a);
        a.addr  = func_addr;
        a.wdata = {FN_PLOT, 12'($urandom)};
        send_access(a);
        pix = x + y * SCR_W;
        if (pix < SCR_W * SCR_H)
        begin
            a.op = OP_SCAN;
            a.px = PIX_W'(pix % SCR_W);
            a.py = PIX_W'(pix / SCR_W);
            send_access(a);
        end
    endtask

    task automatic run_random(input int n);
        int stop;
        stop = accesses_sent + n;
        while (accesses_sent < stop)
        begin
            if ($urandom_range(0, 99) < 30)
                pixel_sequence();
            else
                send_access(random_access());
        end
    endtask

    task automatic test_reset_values();
        issue(OP_RD_WORD, ARG0_ADDR_RST);
        issue(OP_SCAN, '0, '0, 0, 0);
    endtask

    task automatic test_bus_edges();
        issue(OP_WR_WORD, VRAM_BASE_RST, 16'hA5C3);
        issue(OP_RD_WORD, VRAM_BASE_RST);
        issue(OP_WR_BYTE, ADDR_W'(VRAM_BASE_RST + VRAM_BYTES - 1), 16'hFFFF);
        issue(OP_RD_BYTE, ADDR_W'(VRAM_BASE_RST + VRAM_BYTES - 1));
        issue(OP_RD_WORD, ADDR_W'(VRAM_BASE_RST + VRAM_BYTES - 1));
        issue(OP_WR_WORD, ADDR_W'(VRAM_BASE_RST + 3), 16'h1234);
        issue(OP_RD_WORD, ADDR_W'(VRAM_BASE_RST + 3));
        issue(OP_RD_WORD, ADDR_W'(ADDR_MAX));
        issue(3'd7, VRAM_BASE_RST);
    endtask

    task automatic test_register_errors();
        issue(OP_RD_WORD, FUNC_ADDR_RST);
        issue(OP_RD_BYTE, FUNC_ADDR_RST);
    endtask

    task automatic test_functions();
        // column past the width wraps into the next row
        issue(OP_WR_WORD, ARG0_ADDR_RST, 16'd450);
        issue(OP_WR_WORD, ARG1_ADDR_RST, 16'd0);
        issue(OP_WR_WORD, FUNC_ADDR_RST, {FN_PLOT, 12'h002});
        issue(OP_SCAN, '0, '0, 50, 1);
        // pixel byte beyond the VRAM
        issue(OP_WR_WORD, ARG0_ADDR_RST, 16'hFFFF);
        issue(OP_WR_WORD, ARG1_ADDR_RST, 16'hFFFF);
        issue(OP_WR_WORD, FUNC_ADDR_RST, {FN_PLOT, 12'h003});
        issue(OP_WR_WORD, FUNC_ADDR_RST, 16'h9055);
        issue(OP_SCAN, '0, '0, SCR_W - 1, SCR_H - 1);
        issue(OP_SCAN, '0, '0, SCR_W, SCR_H - 1);
        issue(OP_SCAN, '0, '0, SCR_W - 1, SCR_H);
    endtask

    task automatic test_random_default_map();
        run_random(250);
    endtask

    task automatic test_back_to_back();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(150);
        send_idle_pct  = 37;
        recv_stall_pct = 37;
    endtask

    task automatic test_address_maps();
        program_map('0, ADDR_W'(ADDR_MAX), ADDR_W'(VRAM_BYTES), '0);
        run_random(100);
        program_map(ADDR_W'(ADDR_MAX), ADDR_W'(0), ADDR_W'(1), ADDR_W'(ADDR_MAX - 1));
        run_random(100);
        program_map(ADDR_W'(ADDR_MAX + 1 - VRAM_BYTES),
                    ADDR_W'(ADDR_MAX + 1 - VRAM_BYTES + 100),
                    ADDR_W'(1000), ADDR_W'(1000));
        run_random(100);
        program_map(ADDR_W'(100), ADDR_W'(5), ADDR_W'(5), ADDR_W'(ADDR_MAX));
        run_random(100);
        program_map(ADDR_W'(40000), ADDR_W'(2), ADDR_W'(0), ADDR_W'(4));
        run_random(100);
        program_map(VRAM_BASE_RST, FUNC_ADDR_RST, ARG0_ADDR_RST, ARG1_ADDR_RST);
        run_random(100);
    endtask

    initial
    begin
        foreach (vram_image[i])
            vram_image[i] = 8'h00;
        pen_x     = '0;
        pen_y     = '0;
        win_base  = VRAM_BASE_RST;
        func_addr = FUNC_ADDR_RST;
        x_addr    = ARG0_ADDR_RST;
        y_addr    = ARG1_ADDR_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_bus_edges();
        test_register_errors();
        test_functions();
        test_random_default_map();
        test_back_to_back();
        test_address_maps();
        drain();

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: packed_2bpp_display_adapter.f
+incdir+hdl
hdl/p2bda_pkg.sv
hdl/packed_2bpp_display_adapter.sv
hdl/p2bda_checker.sv
test/tb.sv
